/* hdl/tpm_pkg.sv */
// Shared types and constants for the temporal peak and time map block.
// No dependencies; imported by the core, tpm_seq and tpm_update (tpm_ram does not use it).
package tpm_pkg;

    localparam int MAX_PIXELS  = 65536;
    localparam int MAX_FRAMES  = 256;
    localparam int SAMPLE_BITS = 16;

    localparam int PIX_W   = $clog2(MAX_PIXELS);
    localparam int FRAME_W = $clog2(MAX_FRAMES);
    localparam int FC_W    = FRAME_W + 1;
    localparam int PC_W    = PIX_W + 1;
    localparam int PEAK_W  = SAMPLE_BITS + 1;
    localparam int CAND_W  = SAMPLE_BITS + 3;
    localparam int PEAK_LIMIT = (2 ** PEAK_W) - 1;

    // register indexes on the config port
    typedef logic [1:0] cfg_index_t;
    localparam cfg_index_t CFG_FRAME_COUNT = 2'd0;
    localparam cfg_index_t CFG_PIXEL_COUNT = 2'd1;
    localparam cfg_index_t CFG_SMOOTHING   = 2'd2;

    // one per-pixel memory entry
    typedef struct packed {
        logic [PEAK_W-1:0]             peak;
        logic [FRAME_W-1:0]            frame;
        logic signed [SAMPLE_BITS-1:0] prev;
        logic signed [SAMPLE_BITS-1:0] older;
    } entry_t;

    // position and mode of one sample
    typedef struct packed {
        logic [PIX_W-1:0]   px;
        logic [FRAME_W-1:0] k;
        logic               last;
        logic               smooth;
    } pos_t;

endpackage

/* hdl/temporal_peak_and_time_map_core.sv */
// Temporal peak and time map: per-pixel running maximum with frame of peak.
// Result path: a last-frame word passes through stage 1 and then the output register before result_valid rises.
// Throughput: one sample word per cycle unless stage 1 holds a last-frame word behind a full output register.
// Reset: counters and config return to defaults; per-pixel memory is not cleared.
// Depends on tpm_pkg, tpm_seq, tpm_update, tpm_ram.
module temporal_peak_and_time_map_core
    import tpm_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  cfg_index_t                    cfg_index,
    input  logic [PC_W-1:0]               cfg_data,
    input  logic                          sample_valid,
    output logic                          sample_ready,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    output logic                          result_valid,
    input  logic                          result_ready,
    output logic [PIX_W-1:0]              pixel_index,
    output logic [PEAK_W-1:0]             peak_value,
    output logic [FRAME_W-1:0]            peak_frame
);

    // Pipeline:
    //   accept edge: memory read issued for the current pixel, stage 1 loaded
    //   stage 1:     entry (memory or forwarded) updated; written back as it leaves
    //   output reg:  holds a result word until taken
    // Back-to-back words hit the same pixel only with a one-pixel frame; the
    // forward register covers that case since the write and read share an edge.

    pos_t                          pos;
    pos_t                          s1_pos_reg;
    logic                          s1_valid_reg;
    logic signed [SAMPLE_BITS-1:0] s1_sample_reg;
    logic                          fwd_valid_reg;
    entry_t                        fwd_entry_reg;
    logic [$bits(entry_t)-1:0]     ram_rdata;
    entry_t                        rd_entry;
    entry_t                        upd_entry;
    logic                          s1_adv;
    logic                          accept;

    logic                          out_valid_reg;
    logic [PIX_W-1:0]              out_px_reg;
    logic [PEAK_W-1:0]             out_peak_reg;
    logic [FRAME_W-1:0]            out_frame_reg;

    // stage 1 moves on unless it carries a result and the output is full
    assign s1_adv       = s1_valid_reg &&
                          (!s1_pos_reg.last || !out_valid_reg || result_ready);
    assign sample_ready = !s1_valid_reg || s1_adv;
    assign accept       = sample_valid && sample_ready;

    tpm_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .advance   (accept),
        .pos       (pos)
    );

    tpm_ram #(
        .DATA_W ($bits(entry_t)),
        .ADDR_W (PIX_W)
    ) u_ram (
        .clk   (clk),
        .we    (s1_adv),
        .waddr (s1_pos_reg.px),
        .wdata (upd_entry),
        .re    (accept),
        .raddr (pos.px),
        .rdata (ram_rdata)
    );

    assign rd_entry = fwd_valid_reg ? fwd_entry_reg : entry_t'(ram_rdata);

    tpm_update u_update (
        .pos      (s1_pos_reg),
        .sample   (s1_sample_reg),
        .rd_entry (rd_entry),
        .wr_entry (upd_entry)
    );

    // stage 1 control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg  <= 1'b1;
            fwd_valid_reg <= s1_adv && (s1_pos_reg.px == pos.px);
        end
        else if (s1_adv)
        begin
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end
    end

    // stage 1 payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pos_reg    <= pos;
            s1_sample_reg <= sample;
            fwd_entry_reg <= upd_entry;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv && s1_pos_reg.last)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_pos_reg.last)
        begin
            out_px_reg    <= s1_pos_reg.px;
            out_peak_reg  <= upd_entry.peak;
            out_frame_reg <= upd_entry.frame;
        end
    end

    assign result_valid = out_valid_reg;
    assign pixel_index  = out_px_reg;
    assign peak_value   = out_peak_reg;
    assign peak_frame   = out_frame_reg;

    // forwarding only ever serves a word sitting in stage 1
    a_fwd_needs_s1: assert property (@(posedge clk) disable iff (!rst_n)
        fwd_valid_reg |-> s1_valid_reg)
        else $error("forward flag set with stage 1 empty");

    // a word taken while stage 1 is busy means stage 1 is leaving
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s1_valid_reg) |-> s1_adv)
        else $error("stage 1 overwritten");

    // a new result only comes from a last-frame word leaving stage 1
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(s1_adv && s1_pos_reg.last))
        else $error("result without a last-frame word");

endmodule

/* hdl/tpm_ram.sv */
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module tpm_ram #(
    parameter int DATA_W = 8,
    parameter int ADDR_W = 8
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [2**ADDR_W];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* hdl/tpm_seq.sv */
// Config registers and pixel/frame position counters.
// Depends on tpm_pkg.
module tpm_seq
    import tpm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_write,
    input  cfg_index_t       cfg_index,
    input  logic [PC_W-1:0]  cfg_data,
    input  logic             advance,
    output pos_t             pos
);

    logic [FC_W-1:0]    frame_count_reg;
    logic [PC_W-1:0]    pixel_count_reg;
    logic               smooth_reg;
    logic [PIX_W-1:0]   px_reg, px_next;
    logic [FRAME_W-1:0] k_reg, k_next;
    logic [FC_W-1:0]    fc_eff;
    logic [PC_W-1:0]    pc_eff;
    logic [PC_W-1:0]    px_inc;
    logic               last;

    always_comb
    begin
        if (frame_count_reg == '0)
            fc_eff = FC_W'(1);
        else if (frame_count_reg > FC_W'(MAX_FRAMES))
            fc_eff = FC_W'(MAX_FRAMES);
        else
            fc_eff = frame_count_reg;

        if (pixel_count_reg == '0)
            pc_eff = PC_W'(1);
        else if (pixel_count_reg > PC_W'(MAX_PIXELS))
            pc_eff = PC_W'(MAX_PIXELS);
        else
            pc_eff = pixel_count_reg;

        last   = ({1'b0, k_reg} + FC_W'(1)) >= fc_eff;
        px_inc = {1'b0, px_reg} + PC_W'(1);

        if (px_inc >= pc_eff)
        begin
            px_next = '0;
            k_next  = last ? '0 : k_reg + FRAME_W'(1);
        end
        else
        begin
            px_next = px_inc[PIX_W-1:0];
            k_next  = k_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_count_reg <= FC_W'(1);
            pixel_count_reg <= PC_W'(MAX_PIXELS);
            smooth_reg      <= 1'b0;
            px_reg          <= '0;
            k_reg           <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_FRAME_COUNT: frame_count_reg <= cfg_data[FC_W-1:0];
                    CFG_PIXEL_COUNT: pixel_count_reg <= cfg_data;
                    CFG_SMOOTHING:   smooth_reg      <= cfg_data[0];
                    default:         ;
                endcase
            end
            if (advance)
            begin
                px_reg <= px_next;
                k_reg  <= k_next;
            end
        end
    end

    assign pos.px     = px_reg;
    assign pos.k      = k_reg;
    assign pos.last   = last;
    assign pos.smooth = smooth_reg;

endmodule

/* hdl/tpm_update.sv */
// Per-pixel update: candidate forming, peak compare, history shift.
// Depends on tpm_pkg.
module tpm_update
    import tpm_pkg::*;
(
    input  pos_t                          pos,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  entry_t                        rd_entry,
    output entry_t                        wr_entry
);

    // replace peak only on a strictly greater candidate
    function automatic entry_t offer(entry_t e, logic signed [CAND_W-1:0] cand,
                                     logic [FRAME_W-1:0] f);
        entry_t r;
        logic signed [CAND_W-1:0] c;
        r = e;
        c = cand;
        if (c > signed'(CAND_W'(PEAK_LIMIT)))
            c = CAND_W'(PEAK_LIMIT);
        if (c > signed'({{(CAND_W-PEAK_W){1'b0}}, e.peak}))
        begin
            r.peak  = c[PEAK_W-1:0];
            r.frame = f;
        end
        return r;
    endfunction

    logic signed [CAND_W-1:0] cur_ext, prev_ext, older_ext;
    logic signed [CAND_W-1:0] cur_x4, smooth_cand;
    entry_t base, e1, e2;

    always_comb
    begin
        cur_ext   = CAND_W'(sample);
        prev_ext  = CAND_W'(rd_entry.prev);
        older_ext = CAND_W'(rd_entry.older);
        cur_x4    = cur_ext <<< 2;
        // 0.25/0.5/0.25 taps with two fraction bits: 2x + a + b
        smooth_cand = (pos.k == FRAME_W'(1)) ? (prev_ext <<< 2)
                                             : ((prev_ext <<< 1) + older_ext + cur_ext);

        base = rd_entry;
        if (pos.k == '0)
        begin
            base.peak  = '0;
            base.frame = '0;
        end

        if (pos.smooth)
        begin
            e1 = (pos.k != '0) ? offer(base, smooth_cand, pos.k - FRAME_W'(1)) : base;
            e2 = pos.last ? offer(e1, cur_x4, pos.k) : e1;
        end
        else
        begin
            e1 = base;
            e2 = offer(e1, cur_x4, pos.k);
        end

        wr_entry       = e2;
        wr_entry.older = rd_entry.prev;
        wr_entry.prev  = sample;
    end

endmodule
